>>> rtl/chmc_pkg.sv
// Shared types for the monotone chain convex hull unit.
// Command and status groups between controller and datapath.
// No dependencies.
package chmc_pkg;

    // Width of the twice-area field on the output
    localparam int AREA_W = 34;

    // Source of the data written into the point store
    typedef enum logic [1:0] {
        WSEL_IN,
        WSEL_RDA,
        WSEL_T
    } chmc_wsel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       st_we;
        chmc_wsel_t st_wsel;
        logic       st_rd_stk;
        logic       cap_t;
        logic       stk_we;
        logic       area_mode;
        logic       acc_clr;
        logic       acc_add;
        logic       out_load;
        logic       out_last;
    } chmc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pt_gt;
        logic cross_neg;
    } chmc_stat_t;

endpackage

>>> rtl/chmc_dp.sv
// Datapath of the convex hull unit: point store, hull stack, cross product
// pipeline, area accumulator and output register.
// Depends on chmc_pkg.
module chmc_dp #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16,
    parameter int IDX_W       = $clog2(MAX_POINTS),
    parameter int STK_W       = $clog2(2 * MAX_POINTS)
) (
    input  logic                          clk,
    input  chmc_pkg::chmc_cmd_t           cmd,
    output chmc_pkg::chmc_stat_t          stat,
    input  logic [IDX_W-1:0]              st_waddr,
    input  logic [IDX_W-1:0]              st_raddr,
    input  logic [STK_W-1:0]              stk_waddr,
    input  logic [IDX_W-1:0]              stk_wdata,
    input  logic [STK_W-1:0]              stk_raddr_a,
    input  logic [STK_W-1:0]              stk_raddr_b,
    input  logic [2*COORD_WIDTH-1:0]      in_point,
    output logic [COORD_WIDTH-1:0]        vertex_x,
    output logic [COORD_WIDTH-1:0]        vertex_y,
    output logic [chmc_pkg::AREA_W-1:0]   double_area
);
    localparam int CW    = COORD_WIDTH;
    localparam int PT_W  = 2 * CW;
    localparam int D_W   = CW + 1;
    localparam int P_W   = 2 * D_W;
    localparam int X_W   = P_W + 1;
    localparam int SUM_W = X_W + 7;
    localparam int AW    = chmc_pkg::AREA_W;
    localparam int EXT_W = (SUM_W > AW) ? SUM_W : AW + 1;

    logic [PT_W-1:0]  store_mem [MAX_POINTS];
    logic [IDX_W-1:0] stk_mem [2*MAX_POINTS];

    logic [PT_W-1:0]  rda_reg, rdb_reg, t_reg, st_wdata;
    logic [IDX_W-1:0] stk_qa_reg, stk_qb_reg, st_addr_a;

    logic signed [CW-1:0]    ax, ay, bx, by, px, py;
    logic signed [D_W-1:0]   u1_reg, v1_reg, u2_reg, v2_reg;
    logic signed [D_W-1:0]   u1_next, v1_next, u2_next, v2_next;
    logic signed [P_W-1:0]   prod1_reg, prod2_reg;
    logic signed [X_W-1:0]   cross_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0]        abs_sum;
    logic [EXT_W-1:0]        abs_ext;
    logic [AW-1:0]           area_sat;

    logic [CW-1:0] out_x_reg, out_y_reg;
    logic [AW-1:0] out_area_reg;

    // Store write data and read address selection
    always_comb
    begin
        case (cmd.st_wsel)
            chmc_pkg::WSEL_IN:  st_wdata = in_point;
            chmc_pkg::WSEL_RDA: st_wdata = rda_reg;
            chmc_pkg::WSEL_T:   st_wdata = t_reg;
            default:            st_wdata = t_reg;
        endcase
        st_addr_a = cmd.st_rd_stk ? stk_qa_reg : st_raddr;
    end

    // Point store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        rda_reg <= store_mem[st_addr_a];
        rdb_reg <= store_mem[stk_qb_reg];
    end

    // Hull stack: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_qa_reg <= stk_mem[stk_raddr_a];
        stk_qb_reg <= stk_mem[stk_raddr_b];
    end

    assign ax = rda_reg[CW-1:0];
    assign ay = rda_reg[PT_W-1:CW];
    assign bx = rdb_reg[CW-1:0];
    assign by = rdb_reg[PT_W-1:CW];
    assign px = t_reg[CW-1:0];
    assign py = t_reg[PT_W-1:CW];

    // Lexicographic compare of read point against held point
    assign stat.pt_gt     = (ax > px) || ((ax == px) && (ay > py));
    assign stat.cross_neg = cross_reg[X_W-1];

    // Operand stage: differences for turn test, raw coordinates for area
    always_comb
    begin
        if (cmd.area_mode)
        begin
            u1_next = D_W'(ax);
            v1_next = D_W'(by);
            u2_next = D_W'(bx);
            v2_next = D_W'(ay);
        end
        else
        begin
            u1_next = D_W'(px) - D_W'(bx);
            v1_next = D_W'(ay) - D_W'(by);
            u2_next = D_W'(ax) - D_W'(bx);
            v2_next = D_W'(py) - D_W'(by);
        end
    end

    // Free-running operand, product and difference stages, and held point capture
    always_ff @(posedge clk)
    begin
        u1_reg    <= u1_next;
        v1_reg    <= v1_next;
        u2_reg    <= u2_next;
        v2_reg    <= v2_next;
        prod1_reg <= P_W'(u1_reg) * P_W'(v1_reg);
        prod2_reg <= P_W'(u2_reg) * P_W'(v2_reg);
        cross_reg <= X_W'(prod1_reg) - X_W'(prod2_reg);
        if (cmd.cap_t)
        begin
            t_reg <= rda_reg;
        end
    end

    // Shoelace accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            sum_reg <= sum_reg + SUM_W'(cross_reg);
        end
    end

    // Magnitude with saturation to the area field
    always_comb
    begin
        abs_sum  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        abs_ext  = EXT_W'(abs_sum);
        area_sat = (|abs_ext[EXT_W-1:AW]) ? {AW{1'b1}} : abs_ext[AW-1:0];
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_x_reg    <= rda_reg[CW-1:0];
            out_y_reg    <= rda_reg[PT_W-1:CW];
            out_area_reg <= cmd.out_last ? area_sat : '0;
        end
    end

    assign vertex_x    = out_x_reg;
    assign vertex_y    = out_y_reg;
    assign double_area = out_area_reg;

endmodule

>>> rtl/chmc_ctrl.sv
// Controller of the convex hull unit: load, insertion sort, two chain
// passes, area sum and vertex output, with all loop counters.
// Depends on chmc_pkg.
module chmc_ctrl #(
    parameter int MAX_POINTS = 64,
    parameter int IDX_W      = $clog2(MAX_POINTS),
    parameter int STK_W      = $clog2(2 * MAX_POINTS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 m_tlast,
    output chmc_pkg::chmc_cmd_t  cmd,
    input  chmc_pkg::chmc_stat_t stat,
    output logic [IDX_W-1:0]     st_waddr,
    output logic [IDX_W-1:0]     st_raddr,
    output logic [STK_W-1:0]     stk_waddr,
    output logic [IDX_W-1:0]     stk_wdata,
    output logic [STK_W-1:0]     stk_raddr_a,
    output logic [STK_W-1:0]     stk_raddr_b
);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DEP_W = $clog2(2 * MAX_POINTS + 2);

    typedef enum logic [4:0] {
        S_LOAD, S_SORT_I, S_SORT_T, S_SORT_RD, S_SORT_CMP,
        S_HULL_INIT, S_HP_RD, S_HP_CAP, S_HP_CHECK, S_HP_PTS, S_HP_WAIT,
        S_HP_DEC, S_HP_PUSH,
        S_AREA_INIT, S_A_STK, S_A_PTS, S_A_WAIT, S_A_ACC,
        S_E_STK, S_E_PT, S_E_LD, S_E_WAIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg, n_reg, i_reg, j_reg;
    logic [DEP_W-1:0] depth_reg, floor_reg, m_reg, k_reg;
    logic             upper_reg;
    logic [1:0]       wait_reg;

    logic [CNT_W-1:0] jm1;
    logic [DEP_W-1:0] dm1, dm2, k1, knext;
    logic             not_full, k_last;

    assign not_full = count_reg < CNT_W'(MAX_POINTS);
    assign jm1      = j_reg - CNT_W'(1);
    assign dm1      = depth_reg - DEP_W'(1);
    assign dm2      = depth_reg - DEP_W'(2);
    assign k1       = k_reg + DEP_W'(1);
    assign knext    = (k1 < m_reg) ? k1 : '0;
    assign k_last   = (k1 == m_reg);

    // Command decode
    always_comb
    begin
        cmd         = '0;
        cmd.st_wsel = chmc_pkg::WSEL_T;
        st_waddr    = j_reg[IDX_W-1:0];
        st_raddr    = i_reg[IDX_W-1:0];
        stk_waddr   = depth_reg[STK_W-1:0];
        stk_wdata   = i_reg[IDX_W-1:0];
        stk_raddr_a = k_reg[STK_W-1:0];
        stk_raddr_b = knext[STK_W-1:0];
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        m_tlast     = k_last;
        unique case (state_reg)
            S_LOAD:
            begin
                s_tready    = 1'b1;
                cmd.st_we   = s_tvalid && not_full;
                cmd.st_wsel = chmc_pkg::WSEL_IN;
                st_waddr    = count_reg[IDX_W-1:0];
            end
            S_SORT_T, S_HP_CAP:
            begin
                cmd.cap_t = 1'b1;
            end
            S_SORT_RD:
            begin
                cmd.st_we = (j_reg == '0);
                st_raddr  = jm1[IDX_W-1:0];
            end
            S_SORT_CMP:
            begin
                cmd.st_we   = 1'b1;
                cmd.st_wsel = stat.pt_gt ? chmc_pkg::WSEL_RDA : chmc_pkg::WSEL_T;
            end
            S_HULL_INIT:
            begin
                cmd.stk_we = (n_reg == CNT_W'(1));
                stk_waddr  = '0;
                stk_wdata  = '0;
            end
            S_HP_CHECK:
            begin
                stk_raddr_a = dm2[STK_W-1:0];
                stk_raddr_b = dm1[STK_W-1:0];
            end
            S_HP_PTS, S_A_PTS, S_E_PT:
            begin
                cmd.st_rd_stk = 1'b1;
            end
            S_HP_PUSH:
            begin
                cmd.stk_we = 1'b1;
            end
            S_AREA_INIT:
            begin
                cmd.acc_clr = 1'b1;
            end
            S_A_WAIT:
            begin
                cmd.area_mode = 1'b1;
            end
            S_A_ACC:
            begin
                cmd.acc_add = 1'b1;
            end
            S_E_LD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_last = k_last;
            end
            S_E_WAIT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                cmd.st_we = 1'b0;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            depth_reg <= '0;
            floor_reg <= '0;
            m_reg     <= '0;
            k_reg     <= '0;
            upper_reg <= 1'b0;
            wait_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (s_tvalid)
                    begin
                        if (not_full)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (s_tlast)
                        begin
                            n_reg     <= not_full ? count_reg + CNT_W'(1) : count_reg;
                            i_reg     <= CNT_W'(1);
                            state_reg <= S_SORT_I;
                        end
                    end
                end
                S_SORT_I:
                begin
                    state_reg <= (i_reg == n_reg) ? S_HULL_INIT : S_SORT_T;
                end
                S_SORT_T:
                begin
                    j_reg     <= i_reg;
                    state_reg <= S_SORT_RD;
                end
                S_SORT_RD:
                begin
                    if (j_reg == '0)
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_SORT_I;
                    end
                    else
                    begin
                        state_reg <= S_SORT_CMP;
                    end
                end
                S_SORT_CMP:
                begin
                    if (stat.pt_gt)
                    begin
                        j_reg     <= jm1;
                        state_reg <= S_SORT_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_SORT_I;
                    end
                end
                S_HULL_INIT:
                begin
                    count_reg <= '0;
                    if (n_reg == CNT_W'(1))
                    begin
                        m_reg     <= DEP_W'(1);
                        state_reg <= S_AREA_INIT;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        depth_reg <= '0;
                        floor_reg <= DEP_W'(2);
                        upper_reg <= 1'b0;
                        state_reg <= S_HP_RD;
                    end
                end
                S_HP_RD:
                begin
                    state_reg <= S_HP_CAP;
                end
                S_HP_CAP:
                begin
                    state_reg <= S_HP_CHECK;
                end
                S_HP_CHECK:
                begin
                    if ((depth_reg >= floor_reg) && (depth_reg >= DEP_W'(2)))
                    begin
                        state_reg <= S_HP_PTS;
                    end
                    else
                    begin
                        state_reg <= S_HP_PUSH;
                    end
                end
                S_HP_PTS:
                begin
                    wait_reg  <= 2'd2;
                    state_reg <= S_HP_WAIT;
                end
                S_HP_WAIT:
                begin
                    wait_reg <= wait_reg - 2'd1;
                    if (wait_reg == '0)
                    begin
                        state_reg <= S_HP_DEC;
                    end
                end
                S_HP_DEC:
                begin
                    if (stat.cross_neg)
                    begin
                        depth_reg <= dm1;
                        state_reg <= S_HP_CHECK;
                    end
                    else
                    begin
                        state_reg <= S_HP_PUSH;
                    end
                end
                S_HP_PUSH:
                begin
                    depth_reg <= depth_reg + DEP_W'(1);
                    if (!upper_reg)
                    begin
                        state_reg <= S_HP_RD;
                        if (i_reg == n_reg - CNT_W'(1))
                        begin
                            upper_reg <= 1'b1;
                            floor_reg <= depth_reg + DEP_W'(2);
                            i_reg     <= n_reg - CNT_W'(2);
                        end
                        else
                        begin
                            i_reg <= i_reg + CNT_W'(1);
                        end
                    end
                    else if (i_reg == '0)
                    begin
                        m_reg     <= depth_reg;
                        state_reg <= S_AREA_INIT;
                    end
                    else
                    begin
                        i_reg     <= i_reg - CNT_W'(1);
                        state_reg <= S_HP_RD;
                    end
                end
                S_AREA_INIT:
                begin
                    k_reg     <= '0;
                    state_reg <= S_A_STK;
                end
                S_A_STK:
                begin
                    state_reg <= S_A_PTS;
                end
                S_A_PTS:
                begin
                    wait_reg  <= 2'd2;
                    state_reg <= S_A_WAIT;
                end
                S_A_WAIT:
                begin
                    wait_reg <= wait_reg - 2'd1;
                    if (wait_reg == '0)
                    begin
                        state_reg <= S_A_ACC;
                    end
                end
                S_A_ACC:
                begin
                    if (k_last)
                    begin
                        k_reg     <= '0;
                        m_reg     <= (m_reg > DEP_W'(MAX_POINTS)) ? DEP_W'(MAX_POINTS) : m_reg;
                        state_reg <= S_E_STK;
                    end
                    else
                    begin
                        k_reg     <= k1;
                        state_reg <= S_A_STK;
                    end
                end
                S_E_STK:
                begin
                    state_reg <= S_E_PT;
                end
                S_E_PT:
                begin
                    state_reg <= S_E_LD;
                end
                S_E_LD:
                begin
                    state_reg <= S_E_WAIT;
                end
                S_E_WAIT:
                begin
                    if (m_tready)
                    begin
                        if (k_last)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k1;
                            state_reg <= S_E_STK;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

>>> rtl/convex_hull_monotone_chain_unit.sv
// Convex hull unit top level: controller plus datapath.
// Depends on chmc_pkg, chmc_ctrl, chmc_dp.
//
// Points stream in one beat per cycle, the last point of a set marked by
// s_tlast; beyond MAX_POINTS points are dropped. After the last point the
// unit sorts by x then y (insertion sort in the point store), builds the
// lower then upper monotone chain (each turn test reads the hull stack and
// the point store through registered reads and then the three-stage
// multiply pipeline), sums the shoelace area and sends the hull vertices
// counter-clockwise from the leftmost-lowest point, each beat held until
// the sink takes it. The final vertex carries m_tlast and twice the hull
// area; collinear points stay on the hull. No new point is taken until the
// last vertex beat is sent.
module convex_hull_monotone_chain_unit #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // point_x, point_y, zero fill
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]           s_tdata,
    input  logic                                         s_tlast,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // vertex_x, vertex_y, double_area, zero fill
    output logic [((2*COORD_WIDTH+chmc_pkg::AREA_W+7)/8)*8-1:0] m_tdata,
    output logic                                         m_tlast
);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int STK_W = $clog2(2 * MAX_POINTS);
    localparam int OUT_W = ((2*COORD_WIDTH + chmc_pkg::AREA_W + 7) / 8) * 8;

    chmc_pkg::chmc_cmd_t  cmd;
    chmc_pkg::chmc_stat_t stat;
    logic [IDX_W-1:0]     st_waddr, st_raddr, stk_wdata;
    logic [STK_W-1:0]     stk_waddr, stk_raddr_a, stk_raddr_b;
    logic [COORD_WIDTH-1:0]      vertex_x, vertex_y;
    logic [chmc_pkg::AREA_W-1:0] double_area;

    chmc_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W),
        .STK_W      (STK_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tlast     (s_tlast),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat),
        .st_waddr    (st_waddr),
        .st_raddr    (st_raddr),
        .stk_waddr   (stk_waddr),
        .stk_wdata   (stk_wdata),
        .stk_raddr_a (stk_raddr_a),
        .stk_raddr_b (stk_raddr_b)
    );

    chmc_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W),
        .STK_W       (STK_W)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .stat        (stat),
        .st_waddr    (st_waddr),
        .st_raddr    (st_raddr),
        .stk_waddr   (stk_waddr),
        .stk_wdata   (stk_wdata),
        .stk_raddr_a (stk_raddr_a),
        .stk_raddr_b (stk_raddr_b),
        .in_point    (s_tdata[2*COORD_WIDTH-1:0]),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .double_area (double_area)
    );

    // Pack the output beat
    assign m_tdata = OUT_W'({double_area, vertex_y, vertex_x});

endmodule

>>> rtl/chmc_checker.sv
// Port-level checks for the convex hull unit, bound to the top level.
// Depends on convex_hull_monotone_chain_unit and chmc_pkg.
module chmc_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic                                                clk,
    input logic                                                rst_n,
    input logic                                                s_tvalid,
    input logic                                                s_tready,
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0]                  s_tdata,
    input logic                                                s_tlast,
    input logic                                                m_tvalid,
    input logic                                                m_tready,
    input logic [((2*COORD_WIDTH+chmc_pkg::AREA_W+7)/8)*8-1:0] m_tdata,
    input logic                                                m_tlast
);
    localparam int A_LO = 2 * COORD_WIDTH;
    localparam int A_HI = A_LO + chmc_pkg::AREA_W - 1;

    // Loading and result output never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a vertex beat is pending");

    // Closing beat ends the load phase
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("still loading after the last point");

    // Area only on the final vertex
    a_area: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[A_HI:A_LO] == '0))
        else $error("area on a non-final vertex");

    // Stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled vertex beat changed");

endmodule

bind convex_hull_monotone_chain_unit chmc_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_chmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> test/tb_convex_hull_monotone_chain_unit.sv
// Testbench for the monotone chain convex hull unit: streams point sets in,
// checks every hull vertex beat against a built-in hull predictor.
// Depends on chmc_pkg and convex_hull_monotone_chain_unit.
module tb_convex_hull_monotone_chain_unit;

    localparam int MAXP   = 64;
    localparam int CW     = 16;
    localparam int AW     = chmc_pkg::AREA_W;
    localparam int SDW    = ((2*CW+7)/8)*8;
    localparam int MDW    = ((2*CW+AW+7)/8)*8;
    localparam int WD_LIM = 200000;
    localparam int OVF_N  = 66;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               fin;
        logic [AW-1:0]      area;
    } vertex_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               chk;
        logic [AW-1:0]      area;
    } row_t;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [SDW-1:0]  s_tdata;
    logic            s_tlast;
    logic            m_tvalid;
    logic            m_tready;
    logic [MDW-1:0]  m_tdata;
    logic            m_tlast;

    vertex_t hull_q[$];
    int      errors;
    int      idle_cnt;
    bit      calm;

    // point set being collected by the predictor
    int set_x[$];
    int set_y[$];

    convex_hull_monotone_chain_unit #(.MAX_POINTS(MAXP), .COORD_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic longint cross_turn(int ax, int ay, int bx, int by, int px, int py);
        return (longint'(px) - bx) * (longint'(ay) - by)
             - (longint'(ax) - bx) * (longint'(py) - by);
    endfunction

    // predictor: store a point; on the final one compute the hull
    task automatic predict_hull(int px, int py, bit fin);
        int xs[$];
        int ys[$];
        int stk[2*MAXP];
        int dep;
        int n, i, j, tx, ty, floor_d, m;
        longint sum;
        logic [63:0] mag;
        vertex_t v;
        if (set_x.size() < MAXP)
        begin
            set_x.push_back(px);
            set_y.push_back(py);
        end
        if (!fin)
            return;
        xs = set_x;
        ys = set_y;
        set_x.delete();
        set_y.delete();
        n = xs.size();
        for (i = 1; i < n; i++)
        begin
            tx = xs[i]; ty = ys[i]; j = i;
            while (j > 0 && (xs[j-1] > tx || (xs[j-1] == tx && ys[j-1] > ty)))
            begin
                xs[j] = xs[j-1]; ys[j] = ys[j-1]; j--;
            end
            xs[j] = tx; ys[j] = ty;
        end
        dep = 0;
        if (n == 1)
        begin
            stk[0] = 0;
            m = 1;
        end
        else
        begin
            for (i = 0; i < n; i++)
            begin
                while (dep >= 2 && cross_turn(xs[stk[dep-2]], ys[stk[dep-2]],
                       xs[stk[dep-1]], ys[stk[dep-1]], xs[i], ys[i]) < 0)
                    dep--;
                stk[dep] = i;
                dep++;
            end
            floor_d = dep + 1;
            for (i = n - 2; i >= 0; i--)
            begin
                while (dep >= floor_d && dep >= 2 &&
                       cross_turn(xs[stk[dep-2]], ys[stk[dep-2]],
                       xs[stk[dep-1]], ys[stk[dep-1]], xs[i], ys[i]) < 0)
                    dep--;
                stk[dep] = i;
                dep++;
            end
            m = dep - 1;
        end
        sum = 0;
        for (i = 0; i < m; i++)
        begin
            j = (i + 1 < m) ? i + 1 : 0;
            sum += longint'(xs[stk[i]]) * ys[stk[j]] - longint'(xs[stk[j]]) * ys[stk[i]];
        end
        mag = (sum < 0) ? -sum : sum;
        if (mag > {AW{1'b1}})
            mag = {AW{1'b1}};
        if (m > MAXP)
            m = MAXP;
        for (i = 0; i < m; i++)
        begin
            v.x = 16'(xs[stk[i]]);
            v.y = 16'(ys[stk[i]]);
            v.fin = (i + 1 == m);
            v.area = v.fin ? mag[AW-1:0] : '0;
            hull_q.push_back(v);
        end
    endtask

    // drive one point beat, with random gaps ahead of it
    task automatic send_point(int px, int py, bit fin);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {16'(py), 16'(px)};
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_hull(px, py, fin);
    endtask

    // hold the input idle until every expected vertex has come
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (hull_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int rnd_coord();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return int'($urandom_range(0, 20)) - 10;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // sink side: random stall bursts, compare each vertex beat
    initial
    begin
        int stall;
        vertex_t exp_v;
        vertex_t got;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 4);
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[15:0];
                got.y = m_tdata[31:16];
                got.area = m_tdata[32 +: AW];
                got.fin = m_tlast;
                if (hull_q.size() == 0)
                begin
                    $display("%0t: unexpected vertex beat x=%0d y=%0d", $time, got.x, got.y);
                    errors++;
                end
                else
                begin
                    exp_v = hull_q.pop_front();
                    if (got !== exp_v)
                    begin
                        $display("%0t: vertex mismatch exp x=%0d y=%0d last=%0b area=%0d",
                                 $time, exp_v.x, exp_v.y, exp_v.fin, exp_v.area);
                        $display("%0t:                 got x=%0d y=%0d last=%0b area=%0d",
                                 $time, got.x, got.y, got.fin, got.area);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    initial
    begin
        idle_cnt = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cnt = 0;
            else if (++idle_cnt >= WD_LIM)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // main stimulus
    initial
    begin
        row_t dir[$];
        int i, k, n, sent, kind;
        errors = 0;
        calm = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone point, extremes, collinear, duplicates, square
        dir.push_back('{16'sd5, -16'sd7, 1'b1, 1'b1, '0});
        dir.push_back('{-16'sd32768, -16'sd32768, 1'b1, 1'b1, '0});
        dir.push_back('{16'sd32767, 16'sd32767, 1'b1, 1'b1, '0});
        dir.push_back('{16'sd3, 16'sd3, 1'b0, 1'b0, '0});
        dir.push_back('{16'sd3, 16'sd3, 1'b1, 1'b0, '0});
        dir.push_back('{16'sd0, 16'sd0, 1'b0, 1'b0, '0});
        dir.push_back('{16'sd2, 16'sd2, 1'b0, 1'b0, '0});
        dir.push_back('{16'sd1, 16'sd1, 1'b1, 1'b0, '0});
        dir.push_back('{-16'sd32768, -16'sd32768, 1'b0, 1'b0, '0});
        dir.push_back('{16'sd32767, -16'sd32768, 1'b0, 1'b0, '0});
        dir.push_back('{16'sd32767, 16'sd32767, 1'b0, 1'b0, '0});
        dir.push_back('{-16'sd32768, 16'sd32767, 1'b0, 1'b0, '0});
        dir.push_back('{16'sd0, 16'sd0, 1'b1, 1'b1, 34'd8589672450});
        dir.push_back('{16'sd0, 16'sd0, 1'b0, 1'b0, '0});
        dir.push_back('{16'sd4, 16'sd0, 1'b0, 1'b0, '0});
        dir.push_back('{16'sd0, 16'sd4, 1'b0, 1'b0, '0});
        dir.push_back('{16'sd1, 16'sd1, 1'b1, 1'b1, 34'd16});
        foreach (dir[i])
        begin
            send_point(dir[i].x, dir[i].y, dir[i].last);
            // typed-in area check on the final predicted vertex of closing rows marked chk
            if (dir[i].chk && hull_q.size() != 0 && hull_q[$].area !== dir[i].area)
            begin
                $display("%0t: table area exp %0d pred %0d", $time, dir[i].area,
                         hull_q[$].area);
                errors++;
            end
        end
        wait_drained();

        // store overflow: the points past the store are dropped, the last closes
        for (i = 0; i < OVF_N; i++)
            send_point(rnd_coord(), rnd_coord(), i == OVF_N - 1);
        wait_drained();

        // random sets, mostly small; sender holds off once until drained
        sent = dir.size() + OVF_N;
        k = 0;
        while (sent < 160)
        begin
            kind = $urandom_range(0, 9);
            n = (kind == 0) ? $urandom_range(30, 64) : $urandom_range(1, 8);
            if (sent > 130)
                calm = 1;
            for (i = 0; i < n; i++)
            begin
                if (kind == 1)
                    send_point(i * 3 - 9, i * 2 - 6, i == n - 1);
                else if (kind == 2)
                    send_point($urandom_range(0, 3), $urandom_range(0, 3), i == n - 1);
                else
                    send_point(rnd_coord(), rnd_coord(), i == n - 1);
            end
            sent += n;
            k++;
            if (k == 3)
                wait_drained();
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
